### rtl/core/piecewise_linear_gray_map_defines.svh
// Assertion macros shared by the gray map RTL.
`ifndef PIECEWISE_LINEAR_GRAY_MAP_DEFINES_SVH
`define PIECEWISE_LINEAR_GRAY_MAP_DEFINES_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define PLGM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gray map: same-cycle check failed");

// Next-cycle implication, checked at every clock edge outside reset.
`define PLGM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gray map: next-cycle check failed");

`endif

### rtl/core/plgm_pkg.sv
// Types, constants and the divider step function of the gray map.
`default_nettype none

package plgm_pkg;

    localparam int PIX_W        = 8;
    localparam int CFG_COUNT    = 8;
    localparam int CFG_IDX_W    = 3;
    localparam int PROD_W       = 18;
    localparam int NUM_W        = 19;
    localparam int REM_W        = 16;
    localparam int DIV_STAGES   = 4;
    localparam int BITS_PER_DIV = 2;
    localparam int FRONT_STAGES = 4;
    localparam int STAGES       = FRONT_STAGES + DIV_STAGES;

    typedef logic [PIX_W-1:0] pix_t;

    localparam pix_t PIX_MAX = 8'hFF;
    localparam pix_t PIX_ONE = 8'h01;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_BREAK_1  = 3'd0,
        CFG_IN_BREAK_2  = 3'd1,
        CFG_IN_BREAK_3  = 3'd2,
        CFG_IN_BREAK_4  = 3'd3,
        CFG_OUT_LEVEL_1 = 3'd4,
        CFG_OUT_LEVEL_2 = 3'd5,
        CFG_OUT_LEVEL_3 = 3'd6,
        CFG_OUT_LEVEL_4 = 3'd7
    } cfg_idx_t;

    localparam pix_t CFG_RESET [CFG_COUNT] = '{
        8'd0, 8'd85, 8'd170, 8'd255, 8'd0, 8'd85, 8'd170, 8'd255
    };

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic             q_bit;
    } div_step_t;

    // One restoring division step: subtract the shifted divisor if it fits.
    function automatic div_step_t div_step(input logic [REM_W-1:0] rem,
                                           input pix_t             d,
                                           input int unsigned      shift);
        logic [REM_W:0] dsh;
        logic [REM_W:0] diff;
        div_step_t      r;
        dsh  = (REM_W+1)'(d) << shift;
        diff = {1'b0, rem} - dsh;
        if (!diff[REM_W])
        begin
            r.rem   = diff[REM_W-1:0];
            r.q_bit = 1'b1;
        end
        else
        begin
            r.rem   = rem;
            r.q_bit = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/piecewise_linear_gray_map.sv
// A pixel enters stage 0 at its input transfer and its result is offered from the
// last divider stage register. Throughput: one pixel per clock cycle while the
// output is not stalled; the segment select, the two products, the signed sum,
// the range check and four two-bit divider stages are each a stage. A stall at
// the output fills empty stages first, then holds the whole pipe. Reset clears
// every stage valid bit and loads the default identity curve.
`default_nettype none

`include "piecewise_linear_gray_map_defines.svh"

module piecewise_linear_gray_map
    import plgm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [PIX_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [PIX_W-1:0]     gray_in,
    input  wire logic                 frame_end,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [PIX_W-1:0]          gray_out,
    output logic                      clipped,
    output logic                      frame_end_out
);

    pix_t              cfg_reg [CFG_COUNT];
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES:0]   adv;

    // Stage 0: segment select.
    pix_t s0_pix_reg, s0_s_reg, s0_e_reg, s0_ns_reg, s0_ne_reg;
    pix_t s0_s_next, s0_e_next, s0_ns_next, s0_ne_next;
    logic s0_fe_reg;

    // Stage 1: widths and products.
    logic signed [PROD_W-1:0] s1_prod_a_reg, s1_prod_b_reg;
    logic signed [PROD_W-1:0] s1_prod_a_next, s1_prod_b_next;
    logic signed [PIX_W:0]    s1_dorig, s1_dnew, s1_ps, s1_ns_s;
    pix_t                     s1_dabs_reg, s1_dabs_next, s1_ns_reg;
    logic                     s1_neg_reg, s1_zero_reg, s1_fe_reg;

    // Stage 2: numerator, made positive-divisor.
    logic signed [NUM_W-1:0] s2_num_reg, s2_num_next, s2_sum;
    pix_t                    s2_d_reg, s2_ns_reg;
    logic                    s2_zero_reg, s2_fe_reg;

    // Stage 3: range check and divider operands.
    logic [REM_W-1:0] s3_rem_reg, s3_rem_next, s3_limit;
    pix_t             s3_d_reg, s3_d_next;
    logic             s3_clip_reg, s3_clip_next, s3_fe_reg;

    // Divider stages, two quotient bits each.
    logic [REM_W-1:0] dv_rem_reg  [DIV_STAGES];
    logic [REM_W-1:0] dv_rem_next [DIV_STAGES];
    pix_t             dv_d_reg    [DIV_STAGES];
    pix_t             dv_d_in     [DIV_STAGES];
    pix_t             dv_q_reg    [DIV_STAGES];
    pix_t             dv_q_next   [DIV_STAGES];
    logic             dv_clip_reg [DIV_STAGES];
    logic             dv_clip_in  [DIV_STAGES];
    logic             dv_fe_reg   [DIV_STAGES];
    logic             dv_fe_in    [DIV_STAGES];

    // A stage advances when it is empty or the stage after it advances.
    always_comb
    begin
        adv[STAGES] = out_ready;
        for (int i = STAGES - 1; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
        for (int i = 0; i < STAGES; i++)
        begin
            if (i == 0)
            begin
                valid_next[i] = in_valid;
            end
            else
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                if (adv[i])
                begin
                    valid_reg[i] <= valid_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CFG_COUNT; i++)
            begin
                cfg_reg[i] <= CFG_RESET[i];
            end
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    always_comb
    begin
        if (gray_in < cfg_reg[CFG_IN_BREAK_2])
        begin
            s0_s_next  = cfg_reg[CFG_IN_BREAK_1];
            s0_e_next  = cfg_reg[CFG_IN_BREAK_2];
            s0_ns_next = cfg_reg[CFG_OUT_LEVEL_1];
            s0_ne_next = cfg_reg[CFG_OUT_LEVEL_2];
        end
        else if (gray_in < cfg_reg[CFG_IN_BREAK_3])
        begin
            s0_s_next  = cfg_reg[CFG_IN_BREAK_2];
            s0_e_next  = cfg_reg[CFG_IN_BREAK_3];
            s0_ns_next = cfg_reg[CFG_OUT_LEVEL_2];
            s0_ne_next = cfg_reg[CFG_OUT_LEVEL_3];
        end
        else
        begin
            s0_s_next  = cfg_reg[CFG_IN_BREAK_3];
            s0_e_next  = cfg_reg[CFG_IN_BREAK_4];
            s0_ns_next = cfg_reg[CFG_OUT_LEVEL_3];
            s0_ne_next = cfg_reg[CFG_OUT_LEVEL_4];
        end
    end

    // The numerator is ns * dorig + (p - s) * dnew, so nothing is rounded before the divide.
    always_comb
    begin
        s1_dorig       = $signed({1'b0, s0_e_reg}) - $signed({1'b0, s0_s_reg});
        s1_dnew        = $signed({1'b0, s0_ne_reg}) - $signed({1'b0, s0_ns_reg});
        s1_ps          = $signed({1'b0, s0_pix_reg}) - $signed({1'b0, s0_s_reg});
        s1_ns_s        = $signed({1'b0, s0_ns_reg});
        s1_prod_a_next = PROD_W'(s1_ns_s) * PROD_W'(s1_dorig);
        s1_prod_b_next = PROD_W'(s1_ps) * PROD_W'(s1_dnew);
        if (s1_dorig[PIX_W])
        begin
            s1_dabs_next = PIX_W'(-s1_dorig);
        end
        else
        begin
            s1_dabs_next = s1_dorig[PIX_W-1:0];
        end
    end

    always_comb
    begin
        s2_sum = NUM_W'(s1_prod_a_reg) + NUM_W'(s1_prod_b_reg);
        if (s1_neg_reg)
        begin
            s2_num_next = -s2_sum;
        end
        else
        begin
            s2_num_next = s2_sum;
        end
    end

    // Special results are folded into the divider as a value over one.
    always_comb
    begin
        s3_limit = {s2_d_reg, 8'h00};
        if (s2_zero_reg)
        begin
            s3_rem_next  = REM_W'(s2_ns_reg);
            s3_d_next    = PIX_ONE;
            s3_clip_next = 1'b0;
        end
        else if (s2_num_reg[NUM_W-1])
        begin
            s3_rem_next  = '0;
            s3_d_next    = PIX_ONE;
            s3_clip_next = 1'b1;
        end
        else if (s2_num_reg[NUM_W-2:0] >= (NUM_W-1)'(s3_limit))
        begin
            s3_rem_next  = REM_W'(PIX_MAX);
            s3_d_next    = PIX_ONE;
            s3_clip_next = 1'b1;
        end
        else
        begin
            s3_rem_next  = s2_num_reg[REM_W-1:0];
            s3_d_next    = s2_d_reg;
            s3_clip_next = 1'b0;
        end
    end

    always_comb
    begin
        logic [REM_W-1:0] rem;
        pix_t             q;
        div_step_t        st;
        for (int i = 0; i < DIV_STAGES; i++)
        begin
            if (i == 0)
            begin
                rem           = s3_rem_reg;
                q             = '0;
                dv_d_in[i]    = s3_d_reg;
                dv_clip_in[i] = s3_clip_reg;
                dv_fe_in[i]   = s3_fe_reg;
            end
            else
            begin
                rem           = dv_rem_reg[i-1];
                q             = dv_q_reg[i-1];
                dv_d_in[i]    = dv_d_reg[i-1];
                dv_clip_in[i] = dv_clip_reg[i-1];
                dv_fe_in[i]   = dv_fe_reg[i-1];
            end
            for (int j = 0; j < BITS_PER_DIV; j++)
            begin
                st  = div_step(rem, dv_d_in[i],
                               unsigned'(PIX_W - 1 - BITS_PER_DIV * i - j));
                rem = st.rem;
                q   = {q[PIX_W-2:0], st.q_bit};
            end
            dv_rem_next[i] = rem;
            dv_q_next[i]   = q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s0_pix_reg <= gray_in;
            s0_s_reg   <= s0_s_next;
            s0_e_reg   <= s0_e_next;
            s0_ns_reg  <= s0_ns_next;
            s0_ne_reg  <= s0_ne_next;
            s0_fe_reg  <= frame_end;
        end
        if (adv[1])
        begin
            s1_prod_a_reg <= s1_prod_a_next;
            s1_prod_b_reg <= s1_prod_b_next;
            s1_dabs_reg   <= s1_dabs_next;
            s1_neg_reg    <= s1_dorig[PIX_W];
            s1_zero_reg   <= (s1_dorig == '0);
            s1_ns_reg     <= s0_ns_reg;
            s1_fe_reg     <= s0_fe_reg;
        end
        if (adv[2])
        begin
            s2_num_reg  <= s2_num_next;
            s2_d_reg    <= s1_dabs_reg;
            s2_ns_reg   <= s1_ns_reg;
            s2_zero_reg <= s1_zero_reg;
            s2_fe_reg   <= s1_fe_reg;
        end
        if (adv[3])
        begin
            s3_rem_reg  <= s3_rem_next;
            s3_d_reg    <= s3_d_next;
            s3_clip_reg <= s3_clip_next;
            s3_fe_reg   <= s2_fe_reg;
        end
        for (int i = 0; i < DIV_STAGES; i++)
        begin
            if (adv[FRONT_STAGES + i])
            begin
                dv_rem_reg[i]  <= dv_rem_next[i];
                dv_q_reg[i]    <= dv_q_next[i];
                dv_d_reg[i]    <= dv_d_in[i];
                dv_clip_reg[i] <= dv_clip_in[i];
                dv_fe_reg[i]   <= dv_fe_in[i];
            end
        end
    end

    assign in_ready      = adv[0];
    assign out_valid     = valid_reg[STAGES-1];
    assign gray_out      = dv_q_reg[DIV_STAGES-1];
    assign clipped       = dv_clip_reg[DIV_STAGES-1];
    assign frame_end_out = dv_fe_reg[DIV_STAGES-1];

    `PLGM_ASSERT_IMP(a_clip_saturates, out_valid && clipped,
        gray_out == PIX_MAX || gray_out == '0)
    `PLGM_ASSERT_IMP(a_stall_only_when_full, !in_ready, out_valid && !out_ready)
    `PLGM_ASSERT_IMP(a_divisor_nonzero, valid_reg[FRONT_STAGES-1], s3_d_reg != '0)
    `PLGM_ASSERT_IMP(a_remainder_below_divisor, out_valid,
        dv_rem_reg[DIV_STAGES-1] < REM_W'(dv_d_reg[DIV_STAGES-1]))
    `PLGM_ASSERT_NXT(a_transfer_enters, in_valid && in_ready, valid_reg[0])

endmodule

`default_nettype wire

### bench/curve_map_checker.sv
`timescale 1ns / 100ps
// Checker for the gray map: tracks the curve registers, predicts each pixel and checks results.
module curve_map_checker
    import plgm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [PIX_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    input  wire logic                 in_ready,
    input  wire logic [PIX_W-1:0]     gray_in,
    input  wire logic                 frame_end,
    input  wire logic                 out_valid,
    input  wire logic                 out_ready,
    input  wire logic [PIX_W-1:0]     gray_out,
    input  wire logic                 clipped,
    input  wire logic                 frame_end_out,
    output int                        mismatches,
    output int                        pending,
    output int                        results_seen,
    output int                        clips_seen
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        pix_t gray;
        logic clip;
        logic last;
    } mapped_pixel_t;

    pix_t          curve [CFG_COUNT];
    mapped_pixel_t expected_pixels [$];

    // Exact integer evaluation of the segment line, floored, then saturated.
    function automatic mapped_pixel_t map_pixel(input pix_t pixel, input logic last);
        int            start_in;
        int            end_in;
        int            start_out;
        int            end_out;
        int            width;
        int            rise;
        int            num;
        int            level;
        mapped_pixel_t r;
        if (pixel < curve[CFG_IN_BREAK_2])
        begin
            start_in  = curve[CFG_IN_BREAK_1];
            end_in    = curve[CFG_IN_BREAK_2];
            start_out = curve[CFG_OUT_LEVEL_1];
            end_out   = curve[CFG_OUT_LEVEL_2];
        end
        else if (pixel < curve[CFG_IN_BREAK_3])
        begin
            start_in  = curve[CFG_IN_BREAK_2];
            end_in    = curve[CFG_IN_BREAK_3];
            start_out = curve[CFG_OUT_LEVEL_2];
            end_out   = curve[CFG_OUT_LEVEL_3];
        end
        else
        begin
            start_in  = curve[CFG_IN_BREAK_3];
            end_in    = curve[CFG_IN_BREAK_4];
            start_out = curve[CFG_OUT_LEVEL_3];
            end_out   = curve[CFG_OUT_LEVEL_4];
        end
        width = end_in - start_in;
        rise  = end_out - start_out;
        if (width == 0)
        begin
            level = start_out;
        end
        else
        begin
            num = start_out * width + (int'(pixel) - start_in) * rise;
            // A reversed segment is handled by flipping both signs so the divisor is positive.
            if (width < 0)
            begin
                num   = -num;
                width = -width;
            end
            level = num / width;
            if ((num % width) != 0 && num < 0)
            begin
                level = level - 1;
            end
        end
        r.last = last;
        if (level < 0)
        begin
            r.gray = '0;
            r.clip = 1'b1;
        end
        else if (level > int'(PIX_MAX))
        begin
            r.gray = PIX_MAX;
            r.clip = 1'b1;
        end
        else
        begin
            r.gray = pix_t'(level);
            r.clip = 1'b0;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        mapped_pixel_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < CFG_COUNT; i++)
            begin
                curve[i] = CFG_RESET[i];
            end
            expected_pixels.delete();
            mismatches   = 0;
            results_seen = 0;
            clips_seen   = 0;
            pending     <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                curve[cfg_index] = cfg_data;
            end
            // Retire the output transfer before queuing this cycle's input transfer.
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (clipped === 1'b1)
                begin
                    clips_seen++;
                end
                if (expected_pixels.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("%0t: result with no pixel pending: gray %0d clip %b end %b",
                                 $time, gray_out, clipped, frame_end_out);
                    end
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (gray_out !== want.gray || clipped !== want.clip
                        || frame_end_out !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                        begin
                            $display({"%0t: expected gray %0d clip %b end %b, ",
                                      "got gray %0d clip %b end %b"},
                                     $time, want.gray, want.clip, want.last,
                                     gray_out, clipped, frame_end_out);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                expected_pixels.insert(expected_pixels.size(), map_pixel(gray_in, frame_end));
            end
            pending <= expected_pixels.size();
        end
    end

endmodule

### bench/piecewise_linear_gray_map_test.sv
`timescale 1ns / 100ps
// Top of the gray map bench: clock, reset, pixel and curve stimulus, and the verdict.
module piecewise_linear_gray_map_test;
    import plgm_pkg::*;

    localparam int RANDOM_PHASES    = 10;
    localparam int PIXELS_PER_PHASE = 40;
    localparam int BREAKS           = 4;
    localparam int MAX_GAP          = 10;
    localparam int LONG_HOLD        = 80;
    // The longest quiet stretch in a correct run is the long receiver hold plus a curve
    // load; this is several times that.
    localparam int STALL_LIMIT      = 1000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PIX_W-1:0]     cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic [PIX_W-1:0]     gray_in   = '0;
    logic                 frame_end = 1'b0;
    logic                 out_ready = 1'b0;
    logic                 in_ready;
    logic                 out_valid;
    logic [PIX_W-1:0]     gray_out;
    logic                 clipped;
    logic                 frame_end_out;

    int   mismatches;
    int   pending;
    int   results_seen;
    int   clips_seen;
    int   pixels_sent   = 0;
    int   curves_loaded = 0;
    int   idle_cycles   = 0;
    bit   sender_gaps   = 1'b0;
    bit   receiver_gaps = 1'b0;
    bit   hold_request  = 1'b0;
    pix_t curve [CFG_COUNT];

    piecewise_linear_gray_map dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .gray_in       (gray_in),
        .frame_end     (frame_end),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .gray_out      (gray_out),
        .clipped       (clipped),
        .frame_end_out (frame_end_out)
    );

    curve_map_checker scoreboard (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .gray_in       (gray_in),
        .frame_end     (frame_end),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .gray_out      (gray_out),
        .clipped       (clipped),
        .frame_end_out (frame_end_out),
        .mismatches    (mismatches),
        .pending       (pending),
        .results_seen  (results_seen),
        .clips_seen    (clips_seen)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Offers one pixel after an optional random gap and holds it until the transfer.
    task automatic send_pixel(input pix_t value, input logic last);
        int gap;
        gap = sender_gaps ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        gray_in   <= value;
        frame_end <= last;
        do @(posedge clk); while (!in_ready);
        pixels_sent++;
    endtask

    // Drains the pipe, then writes all eight curve registers on consecutive cycles.
    task automatic load_curve();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (STAGES) @(posedge clk);
        for (int i = 0; i < CFG_COUNT; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= cfg_idx_t'(i);
            cfg_data  <= curve[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        curves_loaded++;
    endtask

    initial
    begin : receiver
        int hold;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold         = LONG_HOLD;
                hold_request = 1'b0;
            end
            else
            begin
                hold = receiver_gaps ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin : stimulus
        int   style;
        pix_t swap;
        pix_t pixel;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset curve is the identity; hit both ends and the breakpoints.
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd85, 1'b0);
        send_pixel(8'd170, 1'b0);
        send_pixel(PIX_MAX, 1'b1);

        // Steep stretch: the outer segments extrapolate past 0 and 255.
        curve = '{8'd50, 8'd100, 8'd150, 8'd200, 8'd0, 8'd10, 8'd240, 8'd255};
        load_curve();
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd75, 1'b0);
        send_pixel(8'd149, 1'b1);
        send_pixel(8'd200, 1'b0);
        send_pixel(PIX_MAX, 1'b1);

        // All breakpoints equal, so every segment has zero width.
        curve = '{8'd100, 8'd100, 8'd100, 8'd100, 8'd30, 8'd60, 8'd90, 8'd120};
        load_curve();
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd100, 1'b0);
        send_pixel(PIX_MAX, 1'b1);

        // Breakpoints out of order, giving segments of negative width.
        curve = '{8'd200, 8'd50, 8'd220, 8'd10, 8'd255, 8'd0, 8'd128, 8'd255};
        load_curve();
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd49, 1'b1);
        send_pixel(8'd100, 1'b0);
        send_pixel(PIX_MAX, 1'b0);

        // Full-range inverting segments.
        curve = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd0};
        load_curve();
        send_pixel(8'd0, 1'b1);
        send_pixel(8'd254, 1'b0);
        send_pixel(PIX_MAX, 1'b1);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            style = $urandom_range(0, 5);
            for (int i = 0; i < CFG_COUNT; i++)
            begin
                curve[i] = pix_t'($urandom);
            end
            if (style <= 2)
            begin
                // Ordinary stretch: ascending breakpoints, random output levels.
                for (int i = 0; i < BREAKS - 1; i++)
                begin
                    for (int j = 0; j < BREAKS - 1 - i; j++)
                    begin
                        if (curve[j] > curve[j + 1])
                        begin
                            swap         = curve[j];
                            curve[j]     = curve[j + 1];
                            curve[j + 1] = swap;
                        end
                    end
                end
            end
            else if (style == 3)
            begin
                for (int i = 0; i < CFG_COUNT; i++)
                begin
                    curve[i] = ($urandom_range(0, 1) != 0) ? PIX_MAX : pix_t'(0);
                end
            end
            else if (style == 4)
            begin
                curve[CFG_IN_BREAK_3] = curve[CFG_IN_BREAK_2];
            end
            sender_gaps   = ($urandom_range(0, 2) != 0);
            receiver_gaps = ($urandom_range(0, 2) != 0);
            load_curve();
            if (phase == 2)
            begin
                // Receiver stalls for a long stretch while pixels keep coming back to back.
                hold_request = 1'b1;
                sender_gaps  = 1'b0;
            end
            for (int k = 0; k < PIXELS_PER_PHASE; k++)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    pixel = curve[CFG_IDX_W'($urandom_range(0, BREAKS - 1))]
                            + pix_t'($urandom_range(0, 2)) - PIX_ONE;
                end
                else
                begin
                    pixel = pix_t'($urandom);
                end
                send_pixel(pixel, $urandom_range(0, 7) == 0);
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (2 * STAGES) @(posedge clk);
        $display("Mapped %0d pixels through the reset curve and %0d loaded curves.",
                 pixels_sent, curves_loaded);
        $display("Checked %0d results, %0d of them saturated.", results_seen, clips_seen);
        if (mismatches == 0 && pending == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
